### src/wsdf_pkg.sv
// shared constants for the websocket frame deframer
package wsdf_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned OpcodeW = 4;
  localparam int unsigned KindW   = 2;
  localparam int unsigned LenW    = 64;
  localparam int unsigned KeyW    = 32;
  localparam int unsigned HdrCntW = 3;

  // result kinds
  localparam logic [KindW-1:0] KIND_DATA  = 2'd0;
  localparam logic [KindW-1:0] KIND_EMPTY = 2'd1;
  localparam logic [KindW-1:0] KIND_PONG  = 2'd2;
  localparam logic [KindW-1:0] KIND_ERROR = 2'd3;

  // opcodes with special handling
  localparam logic [OpcodeW-1:0] OP_PING = 4'd9;
  localparam logic [OpcodeW-1:0] OP_PONG = 4'd10;

  // 7-bit length codes that announce an extended length
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // extended length and mask key byte counts, minus one
  localparam logic [HdrCntW-1:0] EXT16_BYTES_M1 = 3'd1;
  localparam logic [HdrCntW-1:0] EXT64_BYTES_M1 = 3'd7;
  localparam logic [HdrCntW-1:0] KEY_BYTES_M1   = 3'd3;

endpackage

### src/websocket_frame_deframer.sv
// websocket frame deframer: header parse, unmask and result register
//
// Takes the received stream one byte per word on the s_axis side and splits it into
// websocket frames. The first header byte gives FIN and the opcode, the second the mask
// bit and 7-bit length, optionally followed by a 16-bit or 64-bit big-endian extended
// length and a 4-byte mask key. Payload bytes are unmasked with key byte (index mod 4)
// and leave on m_axis one per word, tlast marking the last byte of a frame. Ping and
// pong payloads are consumed silently; a ping gives a pong request word at its end, an
// empty data-like frame gives one empty-frame word. An opcode of 4..7 or 12..15 gives
// one error word, and every byte after it is dropped until a word with the
// buffer-start flag (s_axis_tuser) comes in, which restarts the parser at the frame
// header. Throughput is one byte per clock: a byte is parsed by combinational logic in
// the cycle it is accepted and its result lands in a single output register, so the
// input stalls only while that register holds a word that m_axis has not taken.
// The result word of an accepted byte appears on m_axis in the cycle after the byte is accepted.
module websocket_frame_deframer (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tuser,   // [0] buffer_start
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] payload_byte, [11:8] frame_opcode,
                                      // [12] frame_final, [15:13] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast    // last_of_frame
);

  // parser phase
  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXTLEN,
    PH_MASK,
    PH_PAYLOAD,
    PH_DROP
  } phase_t;

  // parser state
  phase_t                          phase, phase_next;
  logic [wsdf_pkg::HdrCntW-1:0]    hdr_count, hdr_count_next;
  logic [wsdf_pkg::LenW-1:0]       remaining_length, remaining_length_next;
  logic [wsdf_pkg::KeyW-1:0]       mask_key, mask_key_next;
  logic                            mask_present, mask_present_next;
  logic [1:0]                      mask_index, mask_index_next;
  logic [wsdf_pkg::OpcodeW-1:0]    held_opcode, held_opcode_next;
  logic                            held_final, held_final_next;

  // result register
  logic                            out_valid;
  logic [wsdf_pkg::KindW-1:0]      out_kind;
  logic [wsdf_pkg::ByteW-1:0]      out_data;
  logic [wsdf_pkg::OpcodeW-1:0]    out_opcode;
  logic                            out_final;
  logic                            out_last;

  // combinational result of the byte being accepted
  logic                            res_valid;
  logic [wsdf_pkg::KindW-1:0]      res_kind;
  logic [wsdf_pkg::ByteW-1:0]      res_data;
  logic                            res_last;

  phase_t                          phase_eff;
  logic                            s_accept;
  logic                            body_start;   // header done, enter payload or end frame
  logic                            pay_last;
  logic [wsdf_pkg::ByteW-1:0]      rx;
  logic [wsdf_pkg::ByteW-1:0]      key_byte;

  // the output register frees up in the same cycle its word is taken
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign rx            = s_axis_tdata;

  // buffer start forces the byte to be read as a first header byte
  assign phase_eff = s_axis_tuser ? PH_HDR0 : phase;

  // first key byte received sits on top of the key register
  assign key_byte = mask_key[{~mask_index, 3'b000} +: 8];
  assign pay_last = (remaining_length == wsdf_pkg::LenW'(1));

  always_comb begin
    phase_next            = phase_eff;
    hdr_count_next        = hdr_count;
    remaining_length_next = remaining_length;
    mask_key_next         = mask_key;
    mask_present_next     = mask_present;
    mask_index_next       = mask_index;
    held_opcode_next      = held_opcode;
    held_final_next       = held_final;
    res_valid             = 1'b0;
    res_kind              = wsdf_pkg::KIND_DATA;
    res_data              = '0;
    res_last              = 1'b0;
    body_start            = 1'b0;

    case (phase_eff)
      PH_HDR1: begin
        mask_present_next = rx[7];
        mask_key_next     = '0;
        if (rx[6:0] == wsdf_pkg::LEN_EXT16) begin
          remaining_length_next = '0;
          hdr_count_next        = wsdf_pkg::EXT16_BYTES_M1;
          phase_next            = PH_EXTLEN;
        end else if (rx[6:0] == wsdf_pkg::LEN_EXT64) begin
          remaining_length_next = '0;
          hdr_count_next        = wsdf_pkg::EXT64_BYTES_M1;
          phase_next            = PH_EXTLEN;
        end else begin
          remaining_length_next = wsdf_pkg::LenW'(rx[6:0]);
          if (rx[7]) begin
            hdr_count_next = wsdf_pkg::KEY_BYTES_M1;
            phase_next     = PH_MASK;
          end else begin
            body_start = 1'b1;
          end
        end
      end
      PH_EXTLEN: begin
        remaining_length_next = {remaining_length[wsdf_pkg::LenW-9:0], rx};
        if (hdr_count != '0) begin
          hdr_count_next = hdr_count - 1'b1;
        end else if (mask_present) begin
          hdr_count_next = wsdf_pkg::KEY_BYTES_M1;
          phase_next     = PH_MASK;
        end else begin
          body_start = 1'b1;
        end
      end
      PH_MASK: begin
        mask_key_next = {mask_key[wsdf_pkg::KeyW-9:0], rx};
        if (hdr_count != '0) begin
          hdr_count_next = hdr_count - 1'b1;
        end else begin
          body_start = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        mask_index_next       = mask_index + 1'b1;
        remaining_length_next = remaining_length - 1'b1;
        if (pay_last) begin
          phase_next = PH_HDR0;
        end
        if (held_opcode == wsdf_pkg::OP_PING) begin
          res_valid = pay_last;
          res_kind  = wsdf_pkg::KIND_PONG;
          res_last  = 1'b1;
        end else if (held_opcode != wsdf_pkg::OP_PONG) begin
          res_valid = 1'b1;
          res_kind  = wsdf_pkg::KIND_DATA;
          res_data  = mask_present ? (rx ^ key_byte) : rx;
          res_last  = pay_last;
        end
      end
      PH_DROP: begin
        phase_next = PH_DROP;
      end
      default: begin
        held_final_next  = rx[7];
        held_opcode_next = rx[3:0];
        hdr_count_next   = '0;
        mask_index_next  = '0;
        if (rx[3:0] inside {[4'd4:4'd7], [4'd12:4'd15]}) begin
          phase_next = PH_DROP;
          res_valid  = 1'b1;
          res_kind   = wsdf_pkg::KIND_ERROR;
          res_last   = 1'b1;
        end else begin
          phase_next = PH_HDR1;
        end
      end
    endcase

    // end of header: payload follows, or the frame is empty
    if (body_start) begin
      mask_index_next = '0;
      if (remaining_length_next != '0) begin
        phase_next = PH_PAYLOAD;
      end else begin
        phase_next = PH_HDR0;
        if (held_opcode == wsdf_pkg::OP_PING) begin
          res_valid = 1'b1;
          res_kind  = wsdf_pkg::KIND_PONG;
          res_last  = 1'b1;
        end else if (held_opcode != wsdf_pkg::OP_PONG) begin
          res_valid = 1'b1;
          res_kind  = wsdf_pkg::KIND_EMPTY;
          res_last  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HDR0;
      hdr_count        <= '0;
      remaining_length <= '0;
      mask_key         <= '0;
      mask_present     <= 1'b0;
      mask_index       <= '0;
      held_opcode      <= '0;
      held_final       <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (s_accept) begin
        phase            <= phase_next;
        hdr_count        <= hdr_count_next;
        remaining_length <= remaining_length_next;
        mask_key         <= mask_key_next;
        mask_present     <= mask_present_next;
        mask_index       <= mask_index_next;
        held_opcode      <= held_opcode_next;
        held_final       <= held_final_next;
      end
      // load a new word, or drop the one just taken
      if (s_accept && res_valid) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload, loaded only with a new word
  always_ff @(posedge clk) begin
    if (s_accept && res_valid) begin
      out_kind   <= res_kind;
      out_data   <= res_data;
      out_opcode <= held_opcode_next;
      out_final  <= held_final_next;
      out_last   <= res_last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_final, out_opcode, out_data};
  assign m_axis_tuser  = out_kind;
  assign m_axis_tlast  = out_last;

  // non-data words always close a frame and carry no byte
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser != wsdf_pkg::KIND_DATA) |->
      (m_axis_tlast && m_axis_tdata[7:0] == 8'h00))
    else $error("control word without last mark or with nonzero byte");

  // payload phase never runs with nothing left to receive
  assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAYLOAD) |-> (remaining_length != '0))
    else $error("payload phase with zero remaining length");

  // the last payload byte sends the parser back to the header
  assert property (@(posedge clk) disable iff (rst)
    (s_accept && !s_axis_tuser && phase == PH_PAYLOAD && pay_last) |=>
      (phase == PH_HDR0))
    else $error("parser did not return to header after last payload byte");

  // once dropping, bytes without buffer start give no words
  assert property (@(posedge clk) disable iff (rst)
    (s_accept && !s_axis_tuser && phase == PH_DROP) |-> !res_valid)
    else $error("result produced while dropping");

  // an error word is always followed by the drop phase
  assert property (@(posedge clk) disable iff (rst)
    (s_accept && res_valid && res_kind == wsdf_pkg::KIND_ERROR) |=>
      (phase == PH_DROP))
    else $error("error word without entering drop phase");

endmodule
